// File: hdl/rzs_pkg.sv
// Package for the rolling z-score signal engine.
// Holds the transfer payload types, FSM state type, control/status structs and codes.
package rzs_pkg;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic REG_ENTRY = 1'b0;
    localparam logic REG_EXIT  = 1'b1;

    localparam int unsigned THR_BITS    = 8;
    localparam logic [7:0]  ENTRY_RESET = 8'd16;
    localparam logic [7:0]  EXIT_RESET  = 8'd1;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  symbol_index;
        logic [23:0] bid_price;
        logic [23:0] ask_price;
        logic        fill_side;
        logic [31:0] fill_quantity;
    } t_in_item;

    typedef struct packed {
        logic        order_side;
        logic [5:0]  order_symbol;
        logic [23:0] order_price;
        logic [31:0] order_quantity;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RING,
        ST_UPD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic fill_wr;
        logic ring_rd;
        logic old_take;
        logic upd;
        logic mul1;
        logic mul2;
        logic mul3;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sym_ok;
        logic is_fill;
        logic full_now;
        logic hit;
    } t_sts;

endpackage

// File: hdl/rzs_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module rzs_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rzs_ctrl.sv
// Controller FSM: sequences clear pass, fills and tick statistics.
// Depends on rzs_pkg.
module rzs_ctrl
    import rzs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.sym_ok) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (i_sts.is_fill) begin
                    o_cmd.fill_wr = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.ring_rd = 1'b1;
                    n_state       = ST_RING;
                end
            end
            ST_RING: begin
                o_cmd.old_take = 1'b1;
                n_state        = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.full_now ? ST_MUL1 : ST_IDLE;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                    if (i_sts.hit) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/rzs_dp.sv
// Datapath: per-symbol state and window RAMs, statistics multiplies, decision.
// Depends on rzs_pkg and rzs_ram.
module rzs_dp
    import rzs_pkg::*;
#(
    parameter int WINDOW_LENGTH = 64,
    parameter int SYMBOL_COUNT  = 64,
    parameter int PRICE_BITS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  t_in_item            i_in,
    input  logic [THR_BITS-1:0] i_entry_q,
    input  logic [THR_BITS-1:0] i_exit_q,
    output t_out_item           o_out
);

    localparam int PW   = PRICE_BITS + 1;
    localparam int LW   = $clog2(WINDOW_LENGTH);
    localparam int PTRW = LW;
    localparam int SYMW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int SUMW = PW + LW;
    localparam int SQW  = 2 * PW + LW;
    localparam int VW   = 2 * SUMW;
    localparam int CW   = VW + THR_BITS;
    localparam int STW  = SUMW + SQW + PTRW + 1 + 32;
    localparam int RAW  = SYMW + PTRW;

    logic [5:0]            r_sym;
    logic                  r_is_fill;
    logic [PRICE_BITS-1:0] r_bid, r_ask;
    logic [PW-1:0]         r_p;
    logic                  r_side;
    logic [31:0]           r_qty;
    logic [2*PW-1:0]       r_pp, r_oo;
    logic [PW-1:0]         r_old;
    logic [SUMW-1:0]       r_sum;
    logic [SQW-1:0]        r_sq;
    logic [PTRW-1:0]       r_wp;
    logic                  r_full;
    logic signed [31:0]    r_pos;
    logic [VW-1:0]         r_vsq, r_s2, r_v, r_b2;
    logic [SUMW-1:0]       r_mag;
    logic                  r_nonneg;
    logic [CW-1:0]         r_lhs, r_rhs;
    logic                  r_vnz;
    logic [SYMW-1:0]       r_clr_idx;
    t_out_item             r_out;

    logic [STW-1:0]        st_rd, st_wd;
    logic                  st_we;
    logic [SYMW-1:0]       st_waddr;
    logic [SUMW-1:0]       rd_sum, n_sum;
    logic [SQW-1:0]        rd_sq, n_sq;
    logic [PTRW-1:0]       rd_wp, n_wp;
    logic                  rd_full, n_full, wp_last;
    logic signed [31:0]    rd_pos, fill_pos;
    logic signed [33:0]    pos_sum;
    logic [PW-1:0]         ring_rd, old_val;
    logic [RAW-1:0]        ring_raddr, ring_waddr;
    logic [SUMW-1:0]       np;
    logic [THR_BITS-1:0]   thr;
    logic                  flat, hit;

    assign {rd_sum, rd_sq, rd_wp, rd_full, rd_pos} = st_rd;

    always_comb begin
        pos_sum = (r_side == SIDE_SELL) ? (34'(rd_pos) - 34'(signed'({2'b00, r_qty})))
                                        : (34'(rd_pos) + 34'(signed'({2'b00, r_qty})));
        if (pos_sum > 34'sd2147483647) begin
            fill_pos = 32'sh7fffffff;
        end else if (pos_sum < -34'sd2147483648) begin
            fill_pos = 32'sh80000000;
        end else begin
            fill_pos = pos_sum[31:0];
        end
    end

    assign wp_last = (r_wp == PTRW'(WINDOW_LENGTH - 1));
    assign n_wp    = wp_last ? '0 : r_wp + 1'b1;
    assign n_full  = r_full | wp_last;
    assign n_sum   = r_sum + SUMW'(r_p) - SUMW'(r_old);
    assign n_sq    = r_sq + SQW'(r_pp) - SQW'(r_oo);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = SYMW'(r_sym);
        st_wd    = '0;
        if (i_cmd.clr_step) begin
            st_we    = 1'b1;
            st_waddr = r_clr_idx;
        end else if (i_cmd.fill_wr) begin
            st_we = 1'b1;
            st_wd = {rd_sum, rd_sq, rd_wp, rd_full, fill_pos};
        end else if (i_cmd.upd) begin
            st_we = 1'b1;
            st_wd = {n_sum, n_sq, n_wp, n_full, r_pos};
        end
    end

    rzs_ram #(.WIDTH(STW), .ADDR_BITS(SYMW)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wd),
        .i_re    (i_cmd.load),
        .i_raddr (SYMW'(i_in.symbol_index)),
        .o_rdata (st_rd)
    );

    assign ring_raddr = {SYMW'(r_sym), rd_wp};
    assign ring_waddr = {SYMW'(r_sym), r_wp};

    rzs_ram #(.WIDTH(PW), .ADDR_BITS(RAW)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd),
        .i_waddr (ring_waddr),
        .i_wdata (r_p),
        .i_re    (i_cmd.ring_rd),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rd)
    );

    // entries past the write pointer are unwritten until the window wraps
    assign old_val = r_full ? ring_rd : '0;
    assign np      = SUMW'(r_p) * SUMW'(WINDOW_LENGTH);
    assign flat    = (r_pos == 32'sd0);
    assign thr     = flat ? i_entry_q : i_exit_q;
    assign hit     = r_vnz && (flat ? (r_lhs >= r_rhs) : (r_lhs <= r_rhs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym     <= i_in.symbol_index;
            r_is_fill <= (i_in.req_type == REQ_FILL);
            r_bid     <= i_in.bid_price[PRICE_BITS-1:0];
            r_ask     <= i_in.ask_price[PRICE_BITS-1:0];
            r_p       <= PW'(i_in.bid_price[PRICE_BITS-1:0])
                       + PW'(i_in.ask_price[PRICE_BITS-1:0]);
            r_side    <= i_in.fill_side;
            r_qty     <= i_in.fill_quantity;
        end
        if (i_cmd.ring_rd) begin
            r_sum  <= rd_sum;
            r_sq   <= rd_sq;
            r_wp   <= rd_wp;
            r_full <= rd_full;
            r_pos  <= rd_pos;
            r_pp   <= r_p * r_p;
        end
        if (i_cmd.old_take) begin
            r_old <= old_val;
            r_oo  <= old_val * old_val;
        end
        if (i_cmd.upd) begin
            r_sum <= n_sum;
            r_sq  <= n_sq;
        end
        if (i_cmd.mul1) begin
            r_vsq    <= VW'(r_sq) * VW'(WINDOW_LENGTH);
            r_s2     <= r_sum * r_sum;
            r_nonneg <= (np >= r_sum);
            r_mag    <= (np >= r_sum) ? (np - r_sum) : (r_sum - np);
        end
        if (i_cmd.mul2) begin
            r_v  <= r_vsq - r_s2;
            r_b2 <= r_mag * r_mag;
        end
        if (i_cmd.mul3) begin
            r_rhs <= r_v * thr;
            r_lhs <= CW'({r_b2, 2'b00});
            r_vnz <= (r_v != '0);
        end
        if (i_cmd.out_load) begin
            r_out.order_symbol <= r_sym;
            if (flat) begin
                r_out.order_side     <= r_nonneg ? SIDE_SELL : SIDE_BUY;
                r_out.order_price    <= 24'(r_nonneg ? r_bid : r_ask);
                r_out.order_quantity <= 32'd1;
            end else begin
                r_out.order_side     <= r_pos[31] ? SIDE_BUY : SIDE_SELL;
                r_out.order_price    <= 24'(r_pos[31] ? r_ask : r_bid);
                r_out.order_quantity <= r_pos[31] ? (32'd0 - r_pos) : r_pos;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_idx == SYMW'(SYMBOL_COUNT - 1));
    assign o_sts.sym_ok   = (32'(i_in.symbol_index) < SYMBOL_COUNT);
    assign o_sts.is_fill  = r_is_fill;
    assign o_sts.full_now = n_full;
    assign o_sts.hit      = hit;
    assign o_out          = r_out;

endmodule

// File: hdl/rolling_zscore_signal_engine_unit.sv
// Flow: a fill is read and written back via READ; an out-of-range symbol stays in IDLE.
// A tick passes READ, RING, UPD and, once its window is full, MUL1, MUL2, MUL3 and DECIDE,
// which waits while an earlier order is stalled, then registers any new order. Items are
// taken one at a time; input is stalled outside IDLE (RAM read-modify-write, multiplies).
// Reset: synchronous; afterwards a clearing pass zeroes all SYMBOL_COUNT entries of the
// per-symbol state RAM while input is stalled. Thresholds reset to 16 and 1.
module rolling_zscore_signal_engine_unit
    import rzs_pkg::*;
#(
    parameter int WINDOW_LENGTH = 64,
    parameter int SYMBOL_COUNT  = 64,
    parameter int PRICE_BITS    = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [THR_BITS-1:0] r_entry_q, r_exit_q;
    t_cmd                cmd;
    t_sts                sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_q <= ENTRY_RESET;
            r_exit_q  <= EXIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ENTRY: r_entry_q <= pwdata[THR_BITS-1:0];
                REG_EXIT:  r_exit_q  <= pwdata[THR_BITS-1:0];
                default:   r_entry_q <= r_entry_q;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ENTRY: prdata = 32'(r_entry_q);
            REG_EXIT:  prdata = 32'(r_exit_q);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    rzs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rzs_dp #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .PRICE_BITS    (PRICE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_in      (i_in_data),
        .i_entry_q (r_entry_q),
        .i_exit_q  (r_exit_q),
        .o_out     (o_out_data)
    );

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during clearing pass");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && sts.sym_ok) |=> o_in_stall)
        else $error("second item taken while one is in flight");

    a_out_only_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !sts.is_fill && sts.hit)
        else $error("order loaded without a tick hit");
`endif

endmodule

// File: tb/sv/rolling_zscore_signal_engine_unit_test.sv
// Testbench for rolling_zscore_signal_engine_unit: directed and random ticks and fills,
// with an in-class predictor of order generation. Depends on rzs_pkg and the DUT.
module rolling_zscore_signal_engine_unit_test
    import rzs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 5000;

    class order_scoreboard;
        logic [24:0] ring [64][64];
        bit [30:0]   win_sum [64];
        bit [55:0]   win_sq [64];
        bit [5:0]    wr_ptr [64];
        bit          full [64];
        int          pos [64];
        bit [7:0]    entry_q;
        bit [7:0]    exit_q;
        t_out_item   orders_due [$];
        int          fails;

        function new();
            foreach (win_sum[s]) begin
                win_sum[s] = 0;
                win_sq[s] = 0;
                wr_ptr[s] = 0;
                full[s] = 0;
                pos[s] = 0;
                for (int k = 0; k < 64; k++) ring[s][k] = 0;
            end
            entry_q = ENTRY_RESET;
            exit_q = EXIT_RESET;
            fails = 0;
        endfunction

        function void set_threshold(logic which, bit [7:0] val);
            if (which == REG_ENTRY) entry_q = val;
            else exit_q = val;
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            fails++;
        endfunction

        function void note_input(t_in_item it);
            int s;
            longint np;
            bit [24:0] p, old;
            bit [127:0] v, lhs, mag;
            bit nonneg;
            t_out_item o;
            s = it.symbol_index;
            if (it.req_type == REQ_FILL) begin
                np = longint'(pos[s]);
                if (it.fill_side == SIDE_SELL) np = np - longint'(it.fill_quantity);
                else np = np + longint'(it.fill_quantity);
                if (np > 64'sd2147483647) np = 64'sd2147483647;
                if (np < -64'sd2147483648) np = -64'sd2147483648;
                pos[s] = int'(np);
                return;
            end
            p = {1'b0, it.bid_price} + {1'b0, it.ask_price};
            old = ring[s][wr_ptr[s]];
            win_sum[s] = win_sum[s] + p - old;
            win_sq[s] = win_sq[s] + 56'(p) * 56'(p) - 56'(old) * 56'(old);
            ring[s][wr_ptr[s]] = p;
            if (wr_ptr[s] == 6'd63) full[s] = 1;
            wr_ptr[s] = wr_ptr[s] + 6'd1;
            if (!full[s]) return;
            v = 128'(win_sq[s]) * 128'd64 - 128'(win_sum[s]) * 128'(win_sum[s]);
            if (v == 0) return;
            nonneg = (128'(p) * 64) >= 128'(win_sum[s]);
            mag = nonneg ? 128'(p) * 64 - 128'(win_sum[s]) : 128'(win_sum[s]) - 128'(p) * 64;
            lhs = 4 * mag * mag;
            o.order_symbol = it.symbol_index;
            if (pos[s] == 0) begin
                if (lhs < v * entry_q) return;
                o.order_side = nonneg ? SIDE_SELL : SIDE_BUY;
                o.order_quantity = 32'd1;
            end else begin
                if (lhs > v * exit_q) return;
                o.order_side = pos[s] > 0 ? SIDE_SELL : SIDE_BUY;
                np = pos[s] > 0 ? longint'(pos[s]) : -longint'(pos[s]);
                o.order_quantity = np[31:0];
            end
            o.order_price = o.order_side == SIDE_SELL ? it.bid_price : it.ask_price;
            orders_due.push_back(o);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (orders_due.size() == 0) begin
                report("unexpected order", got, 0);
                return;
            end
            want = orders_due.pop_front();
            if (got.order_side !== want.order_side)
                report("order_side", got.order_side, want.order_side);
            if (got.order_symbol !== want.order_symbol)
                report("order_symbol", got.order_symbol, want.order_symbol);
            if (got.order_price !== want.order_price)
                report("order_price", got.order_price, want.order_price);
            if (got.order_quantity !== want.order_quantity)
                report("order_quantity", got.order_quantity, want.order_quantity);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_out_item   o_out_data;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    order_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    bit [23:0] base_px [64];

    rolling_zscore_signal_engine_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL rolling_zscore_signal_engine_unit");
                $finish;
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic write_threshold(logic which, bit [7:0] val);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {which, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_threshold(which, val);
    endtask

    task automatic send_transfer(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic drain_orders();
        i_in_valid <= 0;
        while (sb.orders_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item make_fill(bit [5:0] s, logic side, bit [31:0] q);
        t_in_item it;
        it.req_type = REQ_FILL;
        it.symbol_index = s;
        it.bid_price = 24'($urandom());
        it.ask_price = 24'($urandom());
        it.fill_side = side;
        it.fill_quantity = q;
        return it;
    endfunction

    function automatic t_in_item make_tick(bit [5:0] s, bit [23:0] bid, bit [23:0] ask);
        t_in_item it;
        it.req_type = REQ_TICK;
        it.symbol_index = s;
        it.bid_price = bid;
        it.ask_price = ask;
        it.fill_side = 1'($urandom());
        it.fill_quantity = $urandom();
        return it;
    endfunction

    function automatic t_in_item random_transfer();
        bit [5:0] syms [6] = '{0, 1, 2, 3, 62, 63};
        bit [5:0] s;
        bit [24:0] b;
        s = ($urandom_range(19) == 0) ? 6'($urandom()) : syms[$urandom_range(5)];
        if ($urandom_range(99) < 8)
            return make_fill(s, 1'($urandom()),
                ($urandom_range(5) == 0) ? $urandom() : $urandom_range(1, 5));
        if ($urandom_range(99) < 10)
            return make_tick(s, 24'($urandom()), 24'($urandom()));
        b = 25'(base_px[s]) + 25'($urandom_range(0, 40));
        return make_tick(s, b[23:0], b[23:0] + 24'($urandom_range(0, 20)));
    endfunction

    initial begin
        foreach (base_px[s]) base_px[s] = 24'($urandom_range(0, 24'hFFFF00));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        write_threshold(REG_ENTRY, 8'd255);
        write_threshold(REG_EXIT, 8'd0);

        send_transfer(make_fill(63, SIDE_BUY, 32'hFFFFFFFF));
        send_transfer(make_fill(63, SIDE_BUY, 32'hFFFFFFFF));
        send_transfer(make_fill(63, SIDE_SELL, 32'hFFFFFFFF));
        send_transfer(make_fill(63, SIDE_SELL, 32'hFFFFFFFF));
        send_transfer(make_fill(63, SIDE_SELL, 32'hFFFFFFFF));
        send_transfer(make_fill(62, SIDE_BUY, 32'd0));
        send_transfer(make_fill(0, SIDE_SELL, 32'd1));
        send_transfer(make_tick(62, 24'hFFFFFF, 24'hFFFFFF));
        send_transfer(make_tick(62, 24'h000000, 24'h000000));
        send_transfer(make_tick(0, 24'hFFFFFF, 24'h000000));
        send_transfer(make_tick(1, 24'h000000, 24'hFFFFFF));
        send_transfer(make_tick(63, 24'h555555, 24'hAAAAAA));
        // constant prices give a full window of zero variance on symbol 5
        for (int k = 0; k < 66; k++) send_transfer(make_tick(5, 24'h123456, 24'h123458));

        for (int ph = 0; ph < 3; ph++) begin
            drain_orders();
            case (ph)
                0: begin
                    write_threshold(REG_ENTRY, 8'd0);
                    write_threshold(REG_EXIT, 8'd255);
                    send_idle_pct = 6;
                    recv_idle_pct = 84;
                end
                1: begin
                    write_threshold(REG_ENTRY, 8'd255);
                    write_threshold(REG_EXIT, 8'd0);
                    send_idle_pct = 84;
                    recv_idle_pct = 6;
                end
                default: begin
                    write_threshold(REG_ENTRY, 8'd16);
                    write_threshold(REG_EXIT, 8'd1);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 300; n++) send_transfer(random_transfer());
        end

        drain_orders();
        if (sb.fails == 0) $display("PASS rolling_zscore_signal_engine_unit");
        else $display("FAIL rolling_zscore_signal_engine_unit");
        $finish;
    end
endmodule
